[rtl/core/gspool_pkg.sv]
package gspool_pkg;

    localparam int unsigned SLOTS      = 256;
    localparam int unsigned MAX_STRIDE = 65536;
    localparam int unsigned IDX_W      = 8;
    localparam int unsigned CNT_W      = 9;

    localparam logic [1:0] OP_ACQUIRE = 2'd0;
    localparam logic [1:0] OP_RESOLVE = 2'd1;
    localparam logic [1:0] OP_RETIRE  = 2'd2;
    localparam logic [1:0] OP_RECLAIM = 2'd3;

    localparam logic [2:0] STATUS_OK          = 3'd0;
    localparam logic [2:0] STATUS_EXHAUSTED   = 3'd1;
    localparam logic [2:0] STATUS_BAD_HANDLE  = 3'd2;
    localparam logic [2:0] STATUS_BAD_EPOCH   = 3'd3;
    localparam logic [2:0] STATUS_BAD_REQUEST = 3'd4;

    localparam logic [1:0] SLOT_FREE    = 2'd0;
    localparam logic [1:0] SLOT_LIVE    = 2'd1;
    localparam logic [1:0] SLOT_RETIRED = 2'd2;

    localparam logic [2:0] REG_OWNER  = 3'd0;
    localparam logic [2:0] REG_POOL   = 3'd1;
    localparam logic [2:0] REG_COUNT  = 3'd2;
    localparam logic [2:0] REG_STRIDE = 3'd3;
    localparam logic [2:0] REG_BYTES  = 3'd4;

    typedef struct packed {
        logic [63:0]      generation;
        logic [63:0]      last_use;
        logic [CNT_W-1:0] link;
        logic [1:0]       slot_state;
    } entry_t;

    typedef struct packed {
        logic [63:0] failed_allocations;
        logic [24:0] peak_bytes;
        logic [24:0] used_bytes;
        logic [8:0]  reclaimed_count;
        logic [8:0]  visited_count;
        logic [16:0] byte_length;
        logic [23:0] byte_offset;
        logic [63:0] slot_generation;
        logic [8:0]  slot_number;
        logic [2:0]  status;
    } result_t;

endpackage

[rtl/core/generational_slot_pool_epoch_reclaim.sv]
// Channel  | Dir | Signals                          | Word
// s_       | in  | s_tvalid s_tready s_tdata[231:0] | one request
// m_       | out | m_tvalid m_tready m_tdata[255:0] | one result
// apb      | in  | psel penable pwrite paddr pwdata | config register write/read
//
// Acquire, resolve and retire first read the slot table, then check, write
// back and load the result. Reclaim reads the first slot, then visits one
// slot at a time in order (visits = min(budget, slot_count)), all through
// the slot table's single read port and single write port.
// Reset clears slot valid bits at once; an unwritten slot reads as its reset
// value, so no clearing pass is needed. A held result stalls the block only
// when a new one is ready; requests are taken while the output word waits.
module generational_slot_pool_epoch_reclaim
    import gspool_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // op[1:0] handle_owner[33:2] handle_pool[65:34] handle_slot[81:66]
    // handle_generation[145:82] epoch[209:146] visit_budget[225:210], zero pad
    input  logic [231:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[2:0] slot_number[11:3] slot_generation[75:12] byte_offset[99:76]
    // byte_length[116:100] visited_count[125:117] reclaimed_count[134:126]
    // used_bytes[159:135] peak_bytes[184:160] failed_allocations[248:185], pad
    output logic [255:0] m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_PUSH = 2'd3;

    // configuration
    logic [31:0] owner_reg, pool_reg;
    logic [8:0]  count_reg;
    logic [16:0] stride_reg, bytes_reg;

    // control state
    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] scan_reg, scan_next;
    logic [63:0]      completed_reg, completed_next;
    logic [24:0]      used_reg, used_next;
    logic [24:0]      peak_reg, peak_next;
    logic [63:0]      failed_reg, failed_next;
    logic [CNT_W-1:0] remain_reg, remain_next;
    logic [CNT_W-1:0] visits_reg, visits_next;
    logic [CNT_W-1:0] got_reg, got_next;
    logic             m_tvalid_reg, m_tvalid_next;

    // request payload
    logic [1:0]  op_reg, op_next;
    logic        pre_ok_reg, pre_ok_next;
    logic [2:0]  pre_status_reg, pre_status_next;
    logic [63:0] gen_in_reg, gen_in_next;
    logic [63:0] epoch_in_reg, epoch_in_next;
    result_t     out_reg, out_next;
    result_t     res_reg, res_next;

    // slot table
    entry_t           mem [SLOTS];
    logic [SLOTS-1:0] valid_reg;
    entry_t           rd_reg;
    logic             rd_valid_reg;
    logic [IDX_W-1:0] addr_reg;
    logic [IDX_W-1:0] rd_addr;
    logic             mem_we;
    logic [IDX_W-1:0] mem_wa;
    entry_t           mem_wd;

    logic        cfg_we;
    logic [2:0]  cfg_idx;
    logic        reinit;
    logic [8:0]  n_eff;
    logic [16:0] stride_eff, bytes_eff;
    entry_t      ent;
    logic        push_ok;
    logic [24:0] offset_prod;

    // input fields
    logic [1:0]  in_op;
    logic [31:0] in_owner, in_pool;
    logic [15:0] in_slot, in_budget;
    logic [63:0] in_gen, in_epoch;

    assign in_op     = s_tdata[1:0];
    assign in_owner  = s_tdata[33:2];
    assign in_pool   = s_tdata[65:34];
    assign in_slot   = s_tdata[81:66];
    assign in_gen    = s_tdata[145:82];
    assign in_epoch  = s_tdata[209:146];
    assign in_budget = s_tdata[225:210];

    assign cfg_we  = psel & penable & pwrite;
    assign cfg_idx = paddr[4:2];
    assign reinit  = cfg_we && (cfg_idx == REG_COUNT);
    assign pready  = 1'b1;

    always_comb
    begin
        case (cfg_idx)
            REG_OWNER:  prdata = owner_reg;
            REG_POOL:   prdata = pool_reg;
            REG_COUNT:  prdata = {23'd0, count_reg};
            REG_STRIDE: prdata = {15'd0, stride_reg};
            REG_BYTES:  prdata = {15'd0, bytes_reg};
            default:    prdata = 32'd0;
        endcase
    end

    // clamp the configured values into their working ranges
    always_comb
    begin
        if (count_reg == 9'd0)
            n_eff = 9'd1;
        else if (count_reg > 9'(SLOTS))
            n_eff = 9'(SLOTS);
        else
            n_eff = count_reg;
        if (stride_reg == 17'd0)
            stride_eff = 17'd1;
        else if ({7'd0, stride_reg} > 24'(MAX_STRIDE))
            stride_eff = 17'(MAX_STRIDE);
        else
            stride_eff = stride_reg;
        if (bytes_reg == 17'd0)
            bytes_eff = 17'd1;
        else if (bytes_reg > 17'd65536)
            bytes_eff = 17'd65536;
        else
            bytes_eff = bytes_reg;
    end

    // an unwritten entry reads as its reset value
    always_comb
    begin
        if (rd_valid_reg)
            ent = rd_reg;
        else
        begin
            ent.generation = 64'd1;
            ent.last_use   = 64'd0;
            ent.slot_state = SLOT_FREE;
            if ({1'b0, addr_reg} + 9'd1 < n_eff)
                ent.link = {1'b0, addr_reg} + 9'd2;
            else
                ent.link = 9'd0;
        end
    end

    assign offset_prod = addr_reg * stride_eff;
    assign push_ok     = !m_tvalid_reg || m_tready;
    assign s_tready    = (state_reg == S_IDLE);

    always_comb
    begin
        logic       hit;
        logic       recycle;
        logic [8:0] cur_nxt;
        result_t    r;

        state_next      = state_reg;
        head_next       = head_reg;
        scan_next       = scan_reg;
        completed_next  = completed_reg;
        used_next       = used_reg;
        peak_next       = peak_reg;
        failed_next     = failed_reg;
        remain_next     = remain_reg;
        visits_next     = visits_reg;
        got_next        = got_reg;
        op_next         = op_reg;
        pre_ok_next     = pre_ok_reg;
        pre_status_next = pre_status_reg;
        gen_in_next     = gen_in_reg;
        epoch_in_next   = epoch_in_reg;
        res_next        = res_reg;
        out_next        = out_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        rd_addr         = addr_reg;
        mem_we          = 1'b0;
        mem_wa          = addr_reg;
        mem_wd          = ent;
        hit             = 1'b0;
        recycle         = 1'b0;
        cur_nxt         = 9'd0;
        r               = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next         = in_op;
                    gen_in_next     = in_gen;
                    epoch_in_next   = in_epoch;
                    pre_status_next = STATUS_OK;
                    state_next      = S_EXEC;
                    case (in_op)
                        OP_ACQUIRE:
                        begin
                            pre_ok_next = (head_reg != 9'd0) && (head_reg <= n_eff);
                            rd_addr     = IDX_W'(head_reg - 9'd1);
                        end
                        OP_RESOLVE, OP_RETIRE:
                        begin
                            pre_ok_next = (in_owner == owner_reg) && (in_pool == pool_reg)
                                && (in_slot != 16'd0) && (in_slot <= {7'd0, n_eff});
                            rd_addr     = IDX_W'(in_slot - 16'd1);
                        end
                        default:
                        begin
                            pre_ok_next = 1'b0;
                            if (in_owner != owner_reg || in_epoch == 64'd0
                                || in_epoch < completed_reg)
                                pre_status_next = STATUS_BAD_EPOCH;
                            else if (in_budget == 16'd0)
                                pre_status_next = STATUS_BAD_REQUEST;
                            else
                            begin
                                completed_next = in_epoch;
                                if ({1'b0, scan_reg} >= n_eff)
                                    rd_addr = '0;
                                else
                                    rd_addr = scan_reg;
                                if (in_budget < {7'd0, n_eff})
                                    visits_next = 9'(in_budget);
                                else
                                    visits_next = n_eff;
                                remain_next = visits_next;
                                got_next    = 9'd0;
                                state_next  = S_SCAN;
                            end
                        end
                    endcase
                end
            end

            S_EXEC:
            begin
                hit = pre_ok_reg && (ent.slot_state == SLOT_LIVE)
                    && (ent.generation == gen_in_reg);
                case (op_reg)
                    OP_ACQUIRE:
                    begin
                        if (!pre_ok_reg)
                        begin
                            if (failed_reg != '1)
                                failed_next = failed_reg + 64'd1;
                            r.status = STATUS_EXHAUSTED;
                        end
                        else
                        begin
                            head_next         = ent.link;
                            mem_we            = 1'b1;
                            mem_wd.slot_state = SLOT_LIVE;
                            used_next         = used_reg + {8'd0, stride_eff};
                            if (used_next > peak_reg)
                                peak_next = used_next;
                            r.slot_number     = {1'b0, addr_reg} + 9'd1;
                            r.slot_generation = ent.generation;
                            r.byte_offset     = offset_prod[23:0];
                            r.byte_length     = bytes_eff;
                        end
                    end
                    OP_RESOLVE:
                    begin
                        if (hit)
                        begin
                            r.byte_offset = offset_prod[23:0];
                            r.byte_length = bytes_eff;
                        end
                        else
                            r.status = STATUS_BAD_HANDLE;
                    end
                    OP_RETIRE:
                    begin
                        if (!hit)
                            r.status = STATUS_BAD_HANDLE;
                        else if (epoch_in_reg <= completed_reg)
                            r.status = STATUS_BAD_EPOCH;
                        else
                        begin
                            mem_we            = 1'b1;
                            mem_wd.last_use   = epoch_in_reg;
                            mem_wd.slot_state = SLOT_RETIRED;
                        end
                    end
                    default:
                    begin
                        r.status = pre_status_reg;
                    end
                endcase
                r.used_bytes         = used_next;
                r.peak_bytes         = peak_next;
                r.failed_allocations = failed_next;
                if (push_ok)
                begin
                    out_next      = r;
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
                else
                begin
                    res_next   = r;
                    state_next = S_PUSH;
                end
            end

            S_SCAN:
            begin
                // visit the slot read last cycle, fetch the next one
                recycle = (ent.slot_state == SLOT_RETIRED)
                    && (ent.last_use <= completed_reg) && (ent.generation != '1);
                if (recycle)
                begin
                    mem_we            = 1'b1;
                    mem_wd.generation = ent.generation + 64'd1;
                    mem_wd.slot_state = SLOT_FREE;
                    mem_wd.link       = head_reg;
                    head_next         = {1'b0, addr_reg} + 9'd1;
                    if (used_reg >= {8'd0, stride_eff})
                        used_next = used_reg - {8'd0, stride_eff};
                    else
                        used_next = 25'd0;
                    got_next = got_reg + 9'd1;
                end
                cur_nxt = {1'b0, addr_reg} + 9'd1;
                if (cur_nxt >= n_eff)
                    scan_next = '0;
                else
                    scan_next = cur_nxt[IDX_W-1:0];
                rd_addr     = scan_next;
                remain_next = remain_reg - 9'd1;
                if (remain_reg == 9'd1)
                begin
                    r.visited_count      = visits_reg;
                    r.reclaimed_count    = got_next;
                    r.used_bytes         = used_next;
                    r.peak_bytes         = peak_reg;
                    r.failed_allocations = failed_reg;
                    if (push_ok)
                    begin
                        out_next      = r;
                        m_tvalid_next = 1'b1;
                        state_next    = S_IDLE;
                    end
                    else
                    begin
                        res_next   = r;
                        state_next = S_PUSH;
                    end
                end
            end

            S_PUSH:
            begin
                if (push_ok)
                begin
                    out_next      = res_reg;
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // re-chain the pool on a slot_count write
        if (reinit)
        begin
            head_next      = 9'd1;
            scan_next      = '0;
            completed_next = 64'd0;
            used_next      = 25'd0;
            peak_next      = 25'd0;
            failed_next    = 64'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owner_reg     <= 32'd1;
            pool_reg      <= 32'd1;
            count_reg     <= 9'd256;
            stride_reg    <= 17'd64;
            bytes_reg     <= 17'd64;
            state_reg     <= S_IDLE;
            head_reg      <= 9'd1;
            scan_reg      <= '0;
            completed_reg <= 64'd0;
            used_reg      <= 25'd0;
            peak_reg      <= 25'd0;
            failed_reg    <= 64'd0;
            remain_reg    <= 9'd0;
            visits_reg    <= 9'd0;
            got_reg       <= 9'd0;
            m_tvalid_reg  <= 1'b0;
            valid_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx)
                    REG_OWNER:  owner_reg  <= pwdata;
                    REG_POOL:   pool_reg   <= pwdata;
                    REG_COUNT:  count_reg  <= pwdata[8:0];
                    REG_STRIDE: stride_reg <= pwdata[16:0];
                    REG_BYTES:  bytes_reg  <= pwdata[16:0];
                    default:    ;
                endcase
            end
            state_reg     <= state_next;
            head_reg      <= head_next;
            scan_reg      <= scan_next;
            completed_reg <= completed_next;
            used_reg      <= used_next;
            peak_reg      <= peak_next;
            failed_reg    <= failed_next;
            remain_reg    <= remain_next;
            visits_reg    <= visits_next;
            got_reg       <= got_next;
            m_tvalid_reg  <= m_tvalid_next;
            if (reinit)
                valid_reg <= '0;
            else if (mem_we)
                valid_reg[mem_wa] <= 1'b1;
        end
    end

    // payload registers and slot table
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        pre_ok_reg     <= pre_ok_next;
        pre_status_reg <= pre_status_next;
        gen_in_reg     <= gen_in_next;
        epoch_in_reg   <= epoch_in_next;
        res_reg        <= res_next;
        out_reg        <= out_next;
        addr_reg       <= rd_addr;
        rd_reg         <= mem[rd_addr];
        rd_valid_reg   <= valid_reg[rd_addr];
        if (mem_we)
            mem[mem_wa] <= mem_wd;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, out_reg};

endmodule
